// ----- rtl/core/cstf_pkg.sv -----
// ----------------------------------------------------------------------------
// cstf_pkg
// Shared types, constants and the flag-letter table of the character
// stuffing framer.
// ----------------------------------------------------------------------------
`default_nettype none

package cstf_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned WinLen = 6;
  localparam int unsigned WinIdxW = $clog2(WinLen);
  localparam int unsigned QDepth = 2;

  localparam logic [CharW-1:0] ChD = 8'h64;  // 'd'
  localparam logic [CharW-1:0] ChL = 8'h6c;  // 'l'
  localparam logic [CharW-1:0] ChE = 8'h65;  // 'e'
  localparam logic [CharW-1:0] ChS = 8'h73;  // 's'
  localparam logic [CharW-1:0] ChT = 8'h74;  // 't'
  localparam logic [CharW-1:0] ChX = 8'h78;  // 'x'

  localparam logic DirStuff   = 1'b0;
  localparam logic DirDestuff = 1'b1;

  // One job for the output sequencer: optional header, one body character,
  // optional duplicated flag, optional trailer.
  typedef struct packed {
    logic             hdr;
    logic             dup;
    logic             trl;
    logic             fe;
    logic [CharW-1:0] ch;
  } cstf_job_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_BODY,
    PH_DUP,
    PH_TRL
  } cstf_phase_e;

  // Letters of "dlestx" by position.
  function automatic logic [CharW-1:0] flag_char(input logic [2:0] idx);
    logic [CharW-1:0] c;
    begin
      case (idx)
        3'd0:    c = ChD;
        3'd1:    c = ChL;
        3'd2:    c = ChE;
        3'd3:    c = ChS;
        3'd4:    c = ChT;
        default: c = ChX;
      endcase
      return c;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/char_stuffing_framer.sv -----
// ----------------------------------------------------------------------------
// char_stuffing_framer
// Character-stuffing framer with "dlestx" header and trailer and "dle"
// doubling; stuffs outgoing or destuffs received data by direction register.
// ----------------------------------------------------------------------------
// An accepted character's job is registered in the job queue, then in the
// sequencer's job register. Throughput while the output is ready: one
// character per cycle while each yields at most one result; otherwise the
// output sequencer sets one result per cycle (header 6, duplicated flag 3,
// trailer 6 extra characters), buffered by a two-entry job queue.
// Reset: frame state cleared, direction = stuff; no clearing pass.
`default_nettype none

module char_stuffing_framer
  import cstf_pkg::*;
#(
  parameter int unsigned QueueDepth = QDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,      // direction
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,    // [7:0] in_char
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,    // [7:0] out_char
  output logic            m_axis_tlast,
  output logic            m_axis_tuser     // [0] run_last
);

  cstf_job_t front_job, queue_job;
  logic      front_valid, queue_ready, queue_valid, back_pop;

  assign cfg_ready_o = 1'b1;

  cstf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_dir_i   (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .job_valid_o (front_valid),
    .job_o       (front_job),
    .job_ready_i (queue_ready)
  );

  cstf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_valid),
    .push_data_i  (front_job),
    .push_ready_o (queue_ready),
    .pop_i        (back_pop),
    .pop_data_o   (queue_job),
    .pop_valid_o  (queue_valid)
  );

  cstf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (queue_valid),
    .job_i          (queue_job),
    .job_pop_o      (back_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_char_o     (m_axis_tdata),
    .out_fe_o       (m_axis_tlast),
    .out_run_last_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/core/cstf_front.sv -----
// ----------------------------------------------------------------------------
// cstf_front
// Accepts input characters, tracks frame state, matches "dle" when stuffing,
// runs the destuff window, and issues jobs for the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cstf_front
  import cstf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_dir_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [CharW-1:0] in_char_i,
  input  wire logic             in_last_i,
  output logic                  job_valid_o,
  output cstf_job_t             job_o,
  input  wire logic             job_ready_i
);

  logic               dir_q;
  logic               in_frame_q, in_frame_d;
  logic [1:0]         match_q, match_d;
  logic [2:0]         hdr_cnt_q, hdr_cnt_d;
  logic [2:0]         fill_q, fill_d;
  logic               skip_q, skip_d;
  logic [CharW-1:0]   win_q [WinLen];
  logic [CharW-1:0]   win_d [WinLen];
  logic               accept;
  logic               is_pair;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i & job_ready_i;

  assign is_pair = (win_q[0] == ChD) && (win_q[1] == ChL) && (win_q[2] == ChE) &&
                   (win_q[3] == ChD) && (win_q[4] == ChL) && (win_q[5] == ChE);

  always_comb begin
    in_frame_d  = in_frame_q;
    match_d     = match_q;
    hdr_cnt_d   = hdr_cnt_q;
    fill_d      = fill_q;
    skip_d      = skip_q;
    win_d       = win_q;
    job_valid_o = 1'b0;
    job_o       = '{hdr: 1'b0, dup: 1'b0, trl: 1'b0, fe: 1'b0, ch: in_char_i};

    if (accept) begin
      if (dir_q == DirStuff) begin
        job_valid_o = 1'b1;
        job_o.hdr   = ~in_frame_q;
        job_o.trl   = in_last_i;
        in_frame_d  = 1'b1;
        if (in_char_i == ChD) begin
          match_d = 2'd1;
        end else if (match_q == 2'd1 && in_char_i == ChL) begin
          match_d = 2'd2;
        end else if (match_q == 2'd2 && in_char_i == ChE) begin
          job_o.dup = 1'b1;
          match_d   = 2'd0;
        end else begin
          match_d = 2'd0;
        end
        if (in_last_i) begin
          in_frame_d = 1'b0;
          match_d    = 2'd0;
          hdr_cnt_d  = '0;
          fill_d     = '0;
          skip_d     = 1'b0;
        end
      end else begin
        in_frame_d = 1'b1;
        if (hdr_cnt_q < 3'(WinLen)) begin
          // drop header
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end else if (in_last_i) begin
          // oldest goes out, the rest is trailer
          job_valid_o = (fill_q == 3'(WinLen));
          job_o.ch    = win_q[0];
          job_o.fe    = 1'b1;
        end else if (fill_q < 3'(WinLen)) begin
          win_d[fill_q[WinIdxW-1:0]] = in_char_i;
          fill_d = fill_q + 3'd1;
        end else if (!skip_q && is_pair) begin
          // remove the first dle of the pair, keep the copy untested
          win_d[0] = win_q[3];
          win_d[1] = win_q[4];
          win_d[2] = win_q[5];
          win_d[3] = in_char_i;
          fill_d   = 3'd4;
          skip_d   = 1'b1;
        end else begin
          job_valid_o = 1'b1;
          job_o.ch    = win_q[0];
          for (int i = 0; i < WinLen - 1; i++) begin
            win_d[i] = win_q[i+1];
          end
          win_d[WinLen-1] = in_char_i;
          skip_d = 1'b0;
        end
        if (in_last_i) begin
          in_frame_d = 1'b0;
          match_d    = 2'd0;
          hdr_cnt_d  = '0;
          fill_d     = '0;
          skip_d     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= DirStuff;
      in_frame_q <= 1'b0;
      match_q    <= 2'd0;
      hdr_cnt_q  <= '0;
      fill_q     <= '0;
      skip_q     <= 1'b0;
    end else if (cfg_we_i) begin
      // a direction write abandons any frame in progress
      dir_q      <= cfg_dir_i;
      in_frame_q <= 1'b0;
      match_q    <= 2'd0;
      hdr_cnt_q  <= '0;
      fill_q     <= '0;
      skip_q     <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      match_q    <= match_d;
      hdr_cnt_q  <= hdr_cnt_d;
      fill_q     <= fill_d;
      skip_q     <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/cstf_queue.sv -----
// ----------------------------------------------------------------------------
// cstf_queue
// Short job queue between the front and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cstf_queue
  import cstf_pkg::*;
#(
  parameter int unsigned Depth = QDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  cstf_job_t      push_data_i,
  output logic           push_ready_o,
  input  wire logic      pop_i,
  output cstf_job_t      pop_data_o,
  output logic           pop_valid_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw = $clog2(Depth + 1);

  cstf_job_t        mem_q [Depth];
  logic [Aw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [Cw-1:0]    count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != Cw'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  function automatic logic [Aw-1:0] ptr_inc(input logic [Aw-1:0] p);
    begin
      return (p == Aw'(Depth - 1)) ? '0 : p + Aw'(1);
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + Cw'(1);
      else if (do_pop && !do_push) count_q <= count_q - Cw'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// ----- rtl/core/cstf_back.sv -----
// ----------------------------------------------------------------------------
// cstf_back
// Output sequencer: expands each job into header, body, duplicated flag and
// trailer characters, one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cstf_back
  import cstf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  cstf_job_t             job_i,
  output logic                  job_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CharW-1:0]      out_char_o,
  output logic                  out_fe_o,
  output logic                  out_run_last_o
);

  cstf_phase_e phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  cstf_job_t   job_q, job_d;
  logic        step_last;
  logic        take;

  always_comb begin
    unique case (phase_q)
      PH_BODY: step_last = ~job_q.dup & ~job_q.trl;
      PH_DUP:  step_last = (idx_q == 3'd2) & ~job_q.trl;
      PH_TRL:  step_last = (idx_q == 3'd5);
      default: step_last = 1'b0;
    endcase
  end

  assign out_valid_o    = (phase_q != PH_IDLE);
  assign out_char_o     = (phase_q == PH_BODY) ? job_q.ch : flag_char(idx_q);
  assign out_fe_o       = (phase_q == PH_BODY) ? job_q.fe
                                               : ((phase_q == PH_TRL) && (idx_q == 3'd5));
  assign out_run_last_o = step_last;

  // load a new job when idle or when the current one finishes
  assign take      = (phase_q == PH_IDLE) | (out_ready_i & step_last);
  assign job_pop_o = take & job_valid_i;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    job_d   = job_q;
    if (take) begin
      if (job_valid_i) begin
        job_d   = job_i;
        idx_d   = 3'd0;
        phase_d = job_i.hdr ? PH_HDR : PH_BODY;
      end else begin
        phase_d = PH_IDLE;
      end
    end else if (out_ready_i) begin
      unique case (phase_q)
        PH_HDR: begin
          if (idx_q == 3'd5) begin
            phase_d = PH_BODY;
            idx_d   = 3'd0;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        PH_BODY: begin
          phase_d = job_q.dup ? PH_DUP : PH_TRL;
          idx_d   = 3'd0;
        end
        PH_DUP: begin
          if (idx_q == 3'd2) begin
            phase_d = PH_TRL;
            idx_d   = 3'd0;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        PH_TRL:  idx_d = idx_q + 3'd1;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= 3'd0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

`default_nettype wire
